// ===== rtl/kpf_pkg.sv =====
`timescale 1ns / 1ps
package kpf_pkg;
    localparam int NOISE_W = 30;
    localparam int DATA_W = 32;
    localparam int DT_W = 20;
    localparam int ACC_W = 72;
    localparam logic [DATA_W-1:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 30'd16777;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST = 30'd83886;
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 30'd8388608;
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] mx;
        logic signed [ACC_W-1:0] mn;
        mx = ACC_W'(64'sh7FFF_FFFF);
        mn = -ACC_W'(64'sh8000_0000);
        if (x > mx) return 32'h7FFF_FFFF;
        else if (x < mn) return 32'h8000_0000;
        else return x[DATA_W-1:0];
    endfunction
endpackage

// ===== rtl/kalman_pitch_filter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata: measured_angle[31:0] gyro_rate[63:32] time_step[83:64], pad
//                      tuser: operation
// m_axis    out        tdata: filtered_angle[31:0] corrected_rate[63:32] bias_estimate[95:64]
// cfg       in         cfg_index (register number), cfg_data (30-bit noise value)
//
// A restart request goes straight from idle to S_OUT. An update request runs thirteen
// sequencer steps ending in S_OUT, ten of them through one shared 34x33 multiply-accumulate
// unit, plus two gain divisions in the bit-serial divider. s_axis_tready is high whenever
// the sequencer is idle, so the block takes no new request until the last result has left
// S_OUT. A stalled result holds in the output register and only holds the next result in
// S_OUT.
// Reset is synchronous, active low, and restores the noise registers, zero angle and
// bias, and an identity covariance.
module kalman_pitch_filter import kpf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // measured_angle, gyro_rate, time_step, zeros
    input  logic [0:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // filtered_angle, corrected_rate, bias_estimate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_PRED = 4'd1, S_P00 = 4'd2, S_P01 = 4'd3,
        S_P11 = 4'd4, S_DIV0 = 4'd5, S_DIV1 = 4'd6, S_C00 = 4'd7, S_C01 = 4'd8,
        S_C10 = 4'd9, S_C11 = 4'd10, S_CA = 4'd11, S_CB = 4'd12, S_OUT = 4'd13,
        S_WDIV = 4'd14;

    logic [3:0] st_reg;
    logic [3:0] ret_reg;
    logic [NOISE_W-1:0] qa_reg, qb_reg, r_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, rate_reg, k0_reg, k1_reg, err_reg, t0_reg, t1_reg;
    logic [DT_W-1:0] dt_reg;
    logic [95:0] out_reg;
    logic ov_reg;

    // shared multiply unit: a (signed 34) * b (signed 33), rounded shift, added to c
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] mul_c;
    logic               sh24;
    logic signed [ACC_W-1:0] rnd, acc;
    logic signed [31:0] mres;

    always_comb begin
        mul_a = '0; mul_b = '0; mul_c = '0; sh24 = 1'b0;
        unique case (st_reg)
            S_PRED: begin mul_a = 34'(rate_reg) - 34'(bias_reg); mul_b = {13'd0, dt_reg};
                mul_c = ang_reg; end
            S_P00: begin mul_a = $signed({4'd0, qa_reg}) - 34'(p01_reg) - 34'(p10_reg);
                mul_b = {13'd0, dt_reg}; mul_c = p00_reg; end
            S_P01: begin mul_a = -34'(p11_reg); mul_b = {13'd0, dt_reg}; mul_c = p01_reg; end
            S_P11: begin mul_a = $signed({4'd0, qb_reg}); mul_b = {13'd0, dt_reg};
                mul_c = p11_reg; end
            S_C00: begin mul_a = -34'(k0_reg); mul_b = 33'(t0_reg); mul_c = p00_reg;
                sh24 = 1'b1; end
            S_C01: begin mul_a = -34'(k0_reg); mul_b = 33'(t1_reg); mul_c = p01_reg;
                sh24 = 1'b1; end
            S_C10: begin mul_a = -34'(k1_reg); mul_b = 33'(t0_reg); mul_c = p10_reg;
                sh24 = 1'b1; end
            S_C11: begin mul_a = -34'(k1_reg); mul_b = 33'(t1_reg); mul_c = p11_reg;
                sh24 = 1'b1; end
            S_CA: begin mul_a = 34'(k0_reg); mul_b = 33'(err_reg); mul_c = ang_reg;
                sh24 = 1'b1; end
            S_CB: begin mul_a = 34'(k1_reg); mul_b = 33'(err_reg); mul_c = bias_reg;
                sh24 = 1'b1; end
            default: ;
        endcase
    end
    // subtracting round(k*t) equals adding floor(-k*t + half) only if ties agree:
    // round(x) = floor(x+h); -round(x) = -floor(x+h) = ceil(-x-h). Use explicit form.
    logic signed [66:0] pm;
    always_comb begin
        pm = mul_a * mul_b;
        if (sh24 && (st_reg >= S_C00) && (st_reg <= S_C11)) begin
            // pm holds -(k*t); apply round to k*t then negate
            rnd = -(ACC_W'(-pm + 67'sd8388608) >>> 24);
        end else if (sh24) begin
            rnd = ACC_W'(pm + 67'sd8388608) >>> 24;
        end else begin
            rnd = ACC_W'(pm + 67'sd524288) >>> 20;
        end
        acc = ACC_W'(mul_c) + rnd;
        mres = sat32(acc);
    end

    // gain division: divide by |E|, fold the sign of E into the quotient
    logic signed [33:0] esum;
    assign esum = 34'(r_reg) + 34'(p00_reg);
    logic e_zero, e_neg;
    assign e_zero = (esum == 34'sd0);
    assign e_neg = esum[33];
    logic [32:0] den_mag;
    assign den_mag = e_neg ? 33'(-esum) : 33'(esum);

    logic dstart, ddone;
    logic signed [55:0] dnum;
    logic signed [56:0] dquo;
    kpf_div u_div (.aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum),
        .den(den_mag), .done(ddone), .quo(dquo));

    logic signed [55:0] num0, num1;
    assign num0 = {{24{p00_reg[31]}}, p00_reg} <<< 24;
    assign num1 = {{24{p10_reg[31]}}, p10_reg} <<< 24;
    assign dstart = (st_reg == S_DIV0) || (st_reg == S_DIV1);
    assign dnum = (st_reg == S_DIV0) ? num0 : num1;

    logic signed [56:0] squo;
    assign squo = e_neg ? -dquo : dquo;
    logic signed [31:0] qsat;
    assign qsat = sat32(ACC_W'(squo));
    logic signed [33:0] errw;
    assign errw = 34'(meas_reg) - 34'(ang_reg);

    logic s_acc, m_acc, post;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    // post a result once the output register is empty or being drained this cycle
    assign post = (st_reg == S_OUT) && (!ov_reg || m_axis_tready);
    assign s_axis_tready = (st_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; ov_reg <= 1'b0;
            qa_reg <= ANGLE_NOISE_RST; qb_reg <= BIAS_NOISE_RST; r_reg <= MEAS_NOISE_RST;
            ang_reg <= '0; bias_reg <= '0; p00_reg <= ONE_Q24; p01_reg <= '0;
            p10_reg <= '0; p11_reg <= ONE_Q24;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ANGLE_NOISE: qa_reg <= cfg_data[NOISE_W-1:0];
                    REG_BIAS_NOISE:  qb_reg <= cfg_data[NOISE_W-1:0];
                    REG_MEAS_NOISE:  r_reg <= cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (post) ov_reg <= 1'b1;
            else if (m_acc) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (s_acc) begin
                    meas_reg <= s_axis_tdata[31:0];
                    dt_reg <= s_axis_tdata[83:64];
                    if (s_axis_tuser[0] == OP_RESTART) begin
                        // corrected rate reads zero on restart
                        rate_reg <= '0;
                        ang_reg <= s_axis_tdata[31:0]; bias_reg <= '0;
                        p00_reg <= ONE_Q24; p01_reg <= '0; p10_reg <= '0; p11_reg <= ONE_Q24;
                        st_reg <= S_OUT;
                    end else begin
                        rate_reg <= s_axis_tdata[63:32];
                        st_reg <= S_PRED;
                    end
                end
                S_PRED: begin ang_reg <= mres; st_reg <= S_P00; end
                S_P00: begin p00_reg <= mres; st_reg <= S_P01; end
                S_P01: begin p01_reg <= mres; p10_reg <= sat32(ACC_W'(p10_reg) + (acc
                        - ACC_W'(p01_reg))); st_reg <= S_P11; end
                S_P11: begin p11_reg <= mres; err_reg <= sat32(ACC_W'(errw));
                    st_reg <= S_DIV0; end
                S_DIV0: begin ret_reg <= S_DIV1; st_reg <= S_WDIV; end
                S_DIV1: begin ret_reg <= S_C00; st_reg <= S_WDIV; end
                S_WDIV: if (ddone) begin
                    if (ret_reg == S_DIV1) k0_reg <= e_zero ? 32'sd0 : qsat;
                    else k1_reg <= e_zero ? 32'sd0 : qsat;
                    t0_reg <= p00_reg; t1_reg <= p01_reg;
                    st_reg <= ret_reg;
                end
                S_C00: begin p00_reg <= mres; st_reg <= S_C01; end
                S_C01: begin p01_reg <= mres; st_reg <= S_C10; end
                S_C10: begin p10_reg <= mres; st_reg <= S_C11; end
                S_C11: begin p11_reg <= mres; st_reg <= S_CA; end
                S_CA: begin ang_reg <= mres; st_reg <= S_CB; end
                S_CB: begin bias_reg <= mres; st_reg <= S_OUT; end
                S_OUT: if (post) begin
                    out_reg <= {bias_reg, sat32(ACC_W'(rate_reg) - ACC_W'(bias_reg)), ang_reg};
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) m_axis_tvalid && !m_axis_tready
        |=> $stable(m_axis_tdata)) else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn) (st_reg != S_IDLE)
        |-> !s_axis_tready) else $error("ready while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) (st_reg == S_OUT)
        |=> m_axis_tvalid) else $error("result not posted");
endmodule

// ===== rtl/kpf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for signed numerator / positive denominator, one bit a cycle,
// truncating toward zero. done pulses for one cycle once quo holds the final quotient.
module kpf_div import kpf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [55:0]       num,
    input  logic [32:0]              den,
    output logic                     done,
    output logic signed [56:0]       quo
);
    logic [55:0] mag_reg, mag_next;
    logic [56:0] rem_reg, rem_next;
    logic [55:0] q_reg, q_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] den_reg, den_next;
    logic [56:0] trial;

    always_comb begin
        mag_next = mag_reg; rem_next = rem_reg; q_next = q_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; den_next = den_reg; done_next = 1'b0;
        trial = {rem_reg[55:0], mag_reg[55]};
        if (start) begin
            neg_next = num[55];
            mag_next = num[55] ? 56'(-num) : 56'(num);
            rem_next = '0; q_next = '0; cnt_next = 6'd56; busy_next = 1'b1;
            den_next = den;
        end else if (busy_reg) begin
            mag_next = {mag_reg[54:0], 1'b0};
            if (trial >= {24'd0, den_reg}) begin
                rem_next = trial - {24'd0, den_reg};
                q_next = {q_reg[54:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next; rem_reg <= rem_next; q_reg <= q_next;
        neg_reg <= neg_next; den_reg <= den_next;
    end
endmodule

// ===== tb/kpf_checker.sv =====
`timescale 1ns / 1ps
module kpf_checker import kpf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          err_count,
    output int          pending
);
    typedef struct packed {
        logic signed [31:0] bias;
        logic signed [31:0] rate;
        logic signed [31:0] angle;
    } pitch_out_t;

    logic [29:0] qa, qb, rn;
    logic signed [31:0] est_angle, est_bias;
    logic signed [31:0] p00, p01, p10, p11;
    pitch_out_t expected_q[$];

    function automatic logic signed [63:0] clip(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // round half up: add half, then arithmetic shift floors
    function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [63:0] kgain(input logic signed [63:0] p,
                                                 input logic signed [63:0] e);
        if (e == 64'sd0) return 64'sd0;
        return clip((p * 64'sd16777216) / e);
    endfunction

    task automatic filter_step(input logic op, input logic signed [31:0] meas,
                               input logic signed [31:0] rate, input logic [19:0] dt_in);
        logic signed [63:0] dt, err, e, k0, k1, t0, t1, a00, a01, a10, a11, corr;
        pitch_out_t r;
        dt = {44'd0, dt_in};
        corr = 64'sd0;
        if (op == OP_RESTART) begin
            est_angle = meas;
            est_bias = 0;
            p00 = ONE_Q24; p01 = 0; p10 = 0; p11 = ONE_Q24;
        end else begin
            est_angle = 32'(clip(64'(est_angle) + rnd((64'(rate) - est_bias) * dt, 20)));
            err = clip(64'(meas) - est_angle);
            a00 = clip(64'(p00) + rnd(($signed(64'({34'd0, qa})) - p01 - p10) * dt, 20));
            a01 = clip(64'(p01) + rnd(-64'(p11) * dt, 20));
            a10 = clip(64'(p10) + rnd(-64'(p11) * dt, 20));
            a11 = clip(64'(p11) + rnd($signed(64'({34'd0, qb})) * dt, 20));
            e = $signed(64'({34'd0, rn})) + a00;
            k0 = kgain(a00, e);
            k1 = kgain(a10, e);
            t0 = a00;
            t1 = a01;
            p00 = 32'(clip(a00 - rnd(k0 * t0, 24)));
            p01 = 32'(clip(a01 - rnd(k0 * t1, 24)));
            p10 = 32'(clip(a10 - rnd(k1 * t0, 24)));
            p11 = 32'(clip(a11 - rnd(k1 * t1, 24)));
            est_angle = 32'(clip(64'(est_angle) + rnd(k0 * err, 24)));
            est_bias = 32'(clip(64'(est_bias) + rnd(k1 * err, 24)));
            corr = clip(64'(rate) - est_bias);
        end
        r.angle = est_angle;
        r.rate = corr[31:0];
        r.bias = est_bias;
        expected_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        err_count++;
    endtask

    always @(posedge aclk) begin
        pitch_out_t g, x;
        if (!aresetn) begin
            qa <= ANGLE_NOISE_RST; qb <= BIAS_NOISE_RST; rn <= MEAS_NOISE_RST;
            est_angle = 0; est_bias = 0;
            p00 = ONE_Q24; p01 = 0; p10 = 0; p11 = ONE_Q24;
            expected_q.delete();
            err_count = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ANGLE_NOISE: qa <= cfg_data[29:0];
                    REG_BIAS_NOISE:  qb <= cfg_data[29:0];
                    REG_MEAS_NOISE:  rn <= cfg_data[29:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                filter_step(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tdata[83:64]);
            if (m_axis_tvalid && m_axis_tready) begin
                g = m_axis_tdata;
                if (expected_q.size() == 0) begin
                    $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
                    err_count++;
                end else begin
                    x = expected_q.pop_front();
                    if (g.angle !== x.angle) report("filtered_angle", g.angle, x.angle);
                    if (g.rate !== x.rate) report("corrected_rate", g.rate, x.rate);
                    if (g.bias !== x.bias) report("bias_estimate", g.bias, x.bias);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== tb/tb_kalman_pitch_filter.sv =====
`timescale 1ns / 1ps
module tb_kalman_pitch_filter import kpf_pkg::*;;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;  // measured_angle, gyro_rate, time_step, zeros
    logic [0:0]  s_axis_tuser = '0;  // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;      // filtered_angle, corrected_rate, bias_estimate
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          err_count;
    int          pending;

    // idle percentages for sender and receiver
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 1'b0;

    always #1 aclk = ~aclk;

    kalman_pitch_filter u_dut (.*);
    kpf_checker u_chk (.*);

    // Receiver: stall at random, or hold off entirely while hold_off is set.
    always @(posedge aclk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Offer one request; wait out random idles first, then hold until accepted.
    // tvalid stays high after acceptance so the next request can follow at once.
    task automatic send_request(input logic op, input logic [31:0] meas,
                                input logic [31:0] rate, input logic [19:0] dt);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'd0, dt, rate, meas};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Drop the request line and let the checker see the last acceptance.
    task automatic drop_request();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain all results, let the block settle, then write one register.
    task automatic write_noise(input logic [1:0] idx, input logic [31:0] val);
        drop_request();
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Mostly small angles and rates, with occasional full-range values.
    task automatic send_random();
        logic [31:0] meas, rate;
        logic [19:0] dt;
        meas = ($urandom_range(9) == 0) ? $urandom
             : 32'($signed($urandom_range(0, 11796480)) - 5898240);
        rate = ($urandom_range(9) == 0) ? $urandom
             : 32'($signed($urandom_range(0, 26214400)) - 13107200);
        dt = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 2097));
        send_request(($urandom_range(19) == 0) ? OP_RESTART : OP_UPDATE, meas, rate, dt);
    endtask

    initial begin
        #200000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, both operations, zero time step.
        send_request(OP_UPDATE, 32'h0001_0000, 32'h0000_8000, 20'd1049);
        send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
        send_request(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 20'hFFFFF);
        send_request(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
        send_request(OP_UPDATE, 32'h0, 32'h0, 20'd0);
        send_request(OP_RESTART, 32'h8000_0000, 32'hFFFF_FFFF, 20'hFFFFF);
        send_request(OP_RESTART, 32'h7FFF_FFFF, 32'h0, 20'd0);
        send_request(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 20'h80000);
        send_request(OP_RESTART, 32'h0, 32'h0, 20'd0);
        send_request(OP_UPDATE, 32'hFFFF_0000, 32'h0005_0000, 20'd1049);

        // Noise extremes; also a write beyond the register list.
        write_noise(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
        write_noise(REG_BIAS_NOISE, 32'hFFFF_FFFF);
        write_noise(REG_MEAS_NOISE, 32'h3FFF_FFFF);
        write_noise(2'd3, 32'h0);
        repeat (4) send_request(OP_UPDATE, 32'hF000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
        write_noise(REG_ANGLE_NOISE, 32'd0);
        write_noise(REG_BIAS_NOISE, 32'd0);
        write_noise(REG_MEAS_NOISE, 32'd1);
        repeat (4) send_request(OP_UPDATE, 32'h0010_0000, 32'hFFF0_0000, 20'd0);
        send_request(OP_UPDATE, 32'h0010_0000, 32'hFFF0_0000, 20'hFFFFF);

        // Random phases with several noise settings and idle mixes.
        for (int ph = 0; ph < 6; ph++) begin
            write_noise(REG_ANGLE_NOISE, (ph == 5) ? 32'h3FFF_FFFF : $urandom_range(0, 200000));
            write_noise(REG_BIAS_NOISE, (ph == 5) ? 32'h0 : $urandom_range(0, 800000));
            write_noise(REG_MEAS_NOISE, (ph == 5) ? 32'd1 : $urandom_range(1, 30000000));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 60; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 60; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            for (int n = 0; n < 220; n++) send_random();
            // Pause the sender until everything is back.
            drop_request();
            wait (pending == 0);
        end

        // Long receiver hold-off while the sender keeps offering.
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 10; n++) send_random();
                drop_request();
            end
        join

        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (err_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
